// ----- src/thfi_pkg.sv -----
// ---------------------------------------------------------------------------
// thfi_pkg: shared types and constants
// Constants, the arctangent table and the sample/job types for the tilt and
// heading block.
// ---------------------------------------------------------------------------
package thfi_pkg;

   localparam int TabLen = 24;

   // atan(2^-i) in centidegrees with 16 fractional bits
   localparam logic [29:0] AtanTab [TabLen] = '{
      30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507, 30'd23437865,
      30'd11730358, 30'd5866610, 30'd2933484, 30'd1466764, 30'd733385,
      30'd366693, 30'd183346, 30'd91673, 30'd45837, 30'd22918, 30'd11459,
      30'd5730, 30'd2865, 30'd1432, 30'd716, 30'd358, 30'd179, 30'd90, 30'd45
   };

   localparam logic signed [31:0] QuarterTurn = 32'sd589824000;  // 9000 cdeg

   localparam logic [1:0] CsrWeight = 2'd0;
   localparam logic [1:0] CsrDecl   = 2'd1;
   localparam logic [1:0] CsrGain   = 2'd2;

   typedef struct packed {
      logic signed [9:0]  accel_x;
      logic signed [9:0]  accel_y;
      logic signed [9:0]  accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic signed [11:0] field_x;
      logic signed [11:0] field_y;
      logic signed [11:0] field_z;
   } sample_type;

   typedef struct packed {
      logic signed [9:0]  smooth_x;
      logic signed [9:0]  smooth_y;
      logic signed [9:0]  smooth_z;
      logic signed [15:0] roll_cdeg;
      logic signed [14:0] pitch_cdeg;
      logic [15:0]        heading_cdeg;
      logic signed [18:0] turn_x;
      logic signed [18:0] turn_y;
      logic signed [18:0] turn_z;
   } result_type;

   // Job handed from the front to the back: filtered axes, scaled rates,
   // magnetometer axes.
   typedef struct packed {
      logic signed [17:0] sx;
      logic signed [17:0] sy;
      logic signed [17:0] sz;
      logic signed [18:0] turn_x;
      logic signed [18:0] turn_y;
      logic signed [18:0] turn_z;
      logic signed [11:0] field_x;
      logic signed [11:0] field_y;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_ROLL, BK_SQRT, BK_PITCH, BK_HEAD, BK_WRAP, BK_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      FR_IDLE, FR_MUL, FR_PUSH
   } front_state_type;

endpackage

// ----- src/thfi_if.sv -----
// ---------------------------------------------------------------------------
// thfi_if: valid/ready channel
// Carries one payload with valid and ready; source drives, sink accepts.
// ---------------------------------------------------------------------------
interface thfi_if #(
   parameter int Width = 8
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- src/thfi_cordic.sv -----
// ---------------------------------------------------------------------------
// thfi_cordic: iterative atan2
// Vectoring CORDIC, one step per cycle, angle in rounded centidegrees.
// ---------------------------------------------------------------------------
module thfi_cordic #(
   parameter int AngleSteps = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [19:0] y_in,
   input  logic signed [19:0] x_in,
   output logic               done,
   output logic signed [16:0] angle
);
   localparam int CntW = $clog2(AngleSteps + 1);
   // operands are scaled by 2^20; 20 bit inputs plus growth
   localparam int DW = 44;

   logic signed [DW-1:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [31:0]   z_ff, z_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic signed [DW-1:0] xs, ys, dx, dy;
      logic [4:0]           idx;
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      idx = 5'(cnt_ff);
      dx = y_ff >>> idx;
      dy = x_ff >>> idx;
      xs = DW'(x_in) <<< 20;
      ys = DW'(y_in) <<< 20;
      if (start) begin
         z_in = '0;
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_in_n = ys; y_in_n = -xs; z_in = thfi_pkg::QuarterTurn;
            end else begin
               x_in_n = -ys; y_in_n = xs; z_in = -thfi_pkg::QuarterTurn;
            end
         end else begin
            x_in_n = xs; y_in_n = ys;
         end
         cnt_in  = '0;
         if (x_in == 0 && y_in == 0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_n = x_ff + dx; y_in_n = y_ff - dy;
            z_in = z_ff + 32'(thfi_pkg::AtanTab[idx]);
         end else begin
            x_in_n = x_ff - dx; y_in_n = y_ff + dy;
            z_in = z_ff - 32'(thfi_pkg::AtanTab[idx]);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(AngleSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in;
   end

   logic signed [31:0] zr;
   assign zr    = z_ff + 32'sd32768;
   assign done  = done_ff;
   assign angle = 17'(zr >>> 16);
endmodule

// ----- src/thfi_front.sv -----
// ---------------------------------------------------------------------------
// thfi_front: filter and rate scaling
// Accepts a sample, updates the smoothed axes and scales the gyro rates,
// then pushes a job to the queue.
// ---------------------------------------------------------------------------
module thfi_front (
   input  logic                  clock,
   input  logic                  reset,
   thfi_if.sink                  req,
   input  logic [8:0]            weight,
   input  logic [19:0]           gain,
   output logic                  push,
   output thfi_pkg::job_type     job,
   input  logic                  full
);
   thfi_pkg::front_state_type st_ff, st_in;
   thfi_pkg::sample_type      smp_ff;
   logic signed [17:0]        s_ff [3];
   logic [1:0]                k_ff, k_in;
   logic signed [18:0]        t_ff [3];

   thfi_pkg::sample_type smp;
   assign smp = req.data;
   assign req.ready = (st_ff == thfi_pkg::FR_IDLE);

   logic [8:0] w;
   assign w = (weight > 9'd256) ? 9'd256 : weight;

   // One axis and one gyro rate per cycle share the multipliers.
   logic signed [9:0]  a_sel;
   logic signed [15:0] r_sel;
   always_comb begin
      case (k_ff)
         2'd0:    begin a_sel = smp_ff.accel_x; r_sel = smp_ff.rate_x; end
         2'd1:    begin a_sel = smp_ff.accel_y; r_sel = smp_ff.rate_y; end
         default: begin a_sel = smp_ff.accel_z; r_sel = smp_ff.rate_z; end
      endcase
   end

   logic signed [29:0] t_flt;
   logic signed [17:0] s_new;
   logic signed [37:0] prod, pr;
   logic signed [21:0] v;
   logic signed [18:0] sat;
   always_comb begin
      t_flt = 30'(signed'({1'b0, w})) * (30'(a_sel) <<< 8)
            + 30'(signed'({1'b0, 9'd256 - w})) * 30'(s_ff[k_ff]) + 30'sd128;
      s_new = 18'(t_flt >>> 8);
      prod  = 38'(r_sel) * 38'(signed'({1'b0, gain}));
      pr    = prod + 38'sd32768;
      v     = 22'(pr >>> 16);
      if (v > 22'sd262143)       sat = 19'sd262143;
      else if (v < -22'sd262144) sat = -19'sd262144;
      else                       sat = 19'(v);
   end

   always_comb begin
      st_in = st_ff;
      k_in  = k_ff;
      case (st_ff)
         thfi_pkg::FR_IDLE: if (req.valid) begin st_in = thfi_pkg::FR_MUL; k_in = '0; end
         thfi_pkg::FR_MUL: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd2) st_in = thfi_pkg::FR_PUSH;
         end
         thfi_pkg::FR_PUSH: if (!full) st_in = thfi_pkg::FR_IDLE;
         default: st_in = thfi_pkg::FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= thfi_pkg::FR_IDLE;
         k_ff  <= '0;
         s_ff[0] <= '0; s_ff[1] <= '0; s_ff[2] <= '0;
      end else begin
         st_ff <= st_in;
         k_ff  <= k_in;
         if (st_ff == thfi_pkg::FR_MUL) s_ff[k_ff] <= s_new;
      end
      if (req.valid && req.ready) smp_ff <= smp;
      if (st_ff == thfi_pkg::FR_MUL) t_ff[k_ff] <= sat;
   end

   assign push = (st_ff == thfi_pkg::FR_PUSH) && !full;
   always_comb begin
      job.sx = s_ff[0]; job.sy = s_ff[1]; job.sz = s_ff[2];
      job.turn_x = t_ff[0]; job.turn_y = t_ff[1]; job.turn_z = t_ff[2];
      job.field_x = smp_ff.field_x; job.field_y = smp_ff.field_y;
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> $past(st_ff) == thfi_pkg::FR_MUL || $past(st_ff) == thfi_pkg::FR_PUSH)
      else $error("push without a finished job");
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> st_ff == thfi_pkg::FR_MUL && k_ff == 2'd0)
      else $error("accepted sample did not start the filter");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == thfi_pkg::FR_PUSH && full) |=> st_ff == thfi_pkg::FR_PUSH)
      else $error("job lost while queue full");
endmodule

// ----- src/thfi_back.sv -----
// ---------------------------------------------------------------------------
// thfi_back: angle sequencer
// Takes jobs from the queue and runs roll, magnitude, pitch and heading
// through one CORDIC and one bit-pair square root, then holds the result.
// ---------------------------------------------------------------------------
module thfi_back #(
   parameter int AngleSteps = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  jvalid,
   input  thfi_pkg::job_type     job,
   output logic                  pop,
   input  logic signed [15:0]    decl,
   thfi_if.source                rsp
);
   thfi_pkg::back_state_type st_ff, st_in;
   thfi_pkg::job_type        j_ff;
   thfi_pkg::result_type     r_ff;
   logic                     cstart;
   logic signed [19:0]       cy, cx;
   logic                     cdone;
   logic signed [16:0]       cang;

   thfi_cordic #(.AngleSteps(AngleSteps)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .y_in(cy), .x_in(cx),
      .done(cdone), .angle(cang)
   );

   // square root: 36 bit radicand, 18 bit root, one bit pair per cycle
   logic [35:0] n_ff, rt_ff, bit_ff;
   logic [35:0] n_in, rt_in, bit_in;
   logic [35:0] radicand;
   logic [35:0] yy, zz;
   assign yy = 36'(j_ff.sy * j_ff.sy);
   assign zz = 36'(j_ff.sz * j_ff.sz);
   assign radicand = yy + zz;

   logic signed [16:0] cl;
   logic signed [18:0] hsum;
   logic signed [18:0] h_ff, h_in;

   always_comb begin
      st_in  = st_ff;
      cstart = 1'b0;
      cy = '0; cx = '0;
      pop = 1'b0;
      n_in = n_ff; rt_in = rt_ff; bit_in = bit_ff;
      h_in = h_ff;
      hsum = 19'(cang) + 19'(decl);
      case (st_ff)
         thfi_pkg::BK_IDLE: if (jvalid) begin
            pop = 1'b1; st_in = thfi_pkg::BK_ROLL;
         end
         thfi_pkg::BK_ROLL: begin
            if (!cdone) begin
               cstart = (bit_ff == '0) && (n_ff == 36'hFFFFFFFFF);
            end
         end
         default: ;
      endcase
      // The roll step kicks off both the CORDIC and the square root.
      if (st_ff == thfi_pkg::BK_ROLL && cstart) begin
         cy = 20'(j_ff.sy); cx = 20'(j_ff.sz);
         n_in = radicand; rt_in = '0; bit_in = 36'h400000000;
      end else if (bit_ff != '0) begin
         if (n_ff >= rt_ff + bit_ff) begin
            n_in = n_ff - (rt_ff + bit_ff); rt_in = (rt_ff >> 1) + bit_ff;
         end else begin
            rt_in = rt_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      case (st_ff)
         thfi_pkg::BK_ROLL: if (cdone) st_in = thfi_pkg::BK_SQRT;
         thfi_pkg::BK_SQRT: if (bit_ff == '0) begin
            cstart = 1'b1; cy = -20'(j_ff.sx); cx = 20'(rt_ff[17:0]);
            st_in = thfi_pkg::BK_PITCH;
         end
         thfi_pkg::BK_PITCH: if (cdone) begin
            cstart = 1'b1; cy = 20'(j_ff.field_y); cx = 20'(j_ff.field_x);
            st_in = thfi_pkg::BK_HEAD;
         end
         thfi_pkg::BK_HEAD: if (cdone) begin
            h_in = hsum; st_in = thfi_pkg::BK_WRAP;
         end
         thfi_pkg::BK_WRAP: begin
            // sum lies within two turns of zero; one fold per cycle
            if (h_ff < 0) h_in = h_ff + 19'sd36000;
            else if (h_ff >= 19'sd36000) h_in = h_ff - 19'sd36000;
            else st_in = thfi_pkg::BK_DONE;
         end
         thfi_pkg::BK_DONE: if (rsp.ready) st_in = thfi_pkg::BK_IDLE;
         default: ;
      endcase
   end

   always_comb begin
      if (cang > 17'sd18000) cl = 17'sd18000;
      else if (cang < -17'sd18000) cl = -17'sd18000;
      else cl = cang;
   end

   function automatic logic signed [9:0] rnd(input logic signed [17:0] s);
      logic signed [18:0] t;
      logic signed [10:0] q;
      t = 19'(s) + 19'sd128;
      q = 11'(t >>> 8);
      if (q > 11'sd511) return 10'sd511;
      if (q < -11'sd512) return -10'sd512;
      return 10'(q);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= thfi_pkg::BK_IDLE;
         bit_ff <= '0;
         n_ff   <= 36'hFFFFFFFFF;
      end else begin
         st_ff  <= st_in;
         bit_ff <= bit_in;
         if (pop) n_ff <= 36'hFFFFFFFFF;
         else n_ff <= n_in;
      end
      rt_ff <= rt_in;
      h_ff  <= h_in;
      if (pop) j_ff <= job;
      if (st_ff == thfi_pkg::BK_ROLL && cdone) r_ff.roll_cdeg <= 16'(cl);
      if (st_ff == thfi_pkg::BK_PITCH && cdone) begin
         if (cang > 17'sd9000) r_ff.pitch_cdeg <= 15'sd9000;
         else if (cang < -17'sd9000) r_ff.pitch_cdeg <= -15'sd9000;
         else r_ff.pitch_cdeg <= 15'(cang);
      end
      if (st_ff == thfi_pkg::BK_WRAP) r_ff.heading_cdeg <= 16'(h_ff);
      if (pop) begin
         r_ff.smooth_x <= rnd(job.sx);
         r_ff.smooth_y <= rnd(job.sy);
         r_ff.smooth_z <= rnd(job.sz);
         r_ff.turn_x <= job.turn_x;
         r_ff.turn_y <= job.turn_y;
         r_ff.turn_z <= job.turn_z;
      end
   end

   assign rsp.valid = (st_ff == thfi_pkg::BK_DONE);
   assign rsp.data  = r_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !pop)
      else $error("job taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == thfi_pkg::BK_SQRT && bit_ff != '0) |=> st_ff == thfi_pkg::BK_SQRT)
      else $error("pitch started before root finished");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == thfi_pkg::BK_WRAP && st_in == thfi_pkg::BK_DONE) |->
      (h_ff >= 0 && h_ff < 19'sd36000))
      else $error("heading out of range");
endmodule

// ----- src/tilt_heading_from_imu.sv -----
// ---------------------------------------------------------------------------
// tilt_heading_from_imu: tilt and compass heading from an IMU sample
// Exponential accelerometer filter, CORDIC roll/pitch/heading, scaled gyro.
// ---------------------------------------------------------------------------
// A sample goes from its transfer to its result as follows: the front runs the
// filter and gyro multiplies one axis at a time, then the back runs one shared
// CORDIC three times, for roll, pitch and heading. The 18 step square root
// runs beside the roll angle and, at sixteen steps or fewer, holds pitch back
// until it is done. Heading wrap and a state holding the result follow. The
// back works on one sample at a time and takes the next job only after its
// result is taken, which sets the throughput. A two-entry queue between front
// and back lets the next sample be filtered while the previous one is still
// in the angle unit, and the front keeps taking samples while a held result
// waits for rsp_ready until the queue fills.
module tilt_heading_from_imu #(
   parameter int ANGLE_STEPS = 16
) (
   input  logic  clock,
   input  logic  reset,
   thfi_if.sink  req,
   thfi_if.source rsp,
   thfi_if.sink  csr
);
   logic [8:0]         weight_ff;
   logic signed [15:0] decl_ff;
   logic [19:0]        gain_ff;
   logic [1:0]         cidx;
   logic [19:0]        cdat;

   assign csr.ready = 1'b1;
   assign cidx = csr.data[21:20];
   assign cdat = csr.data[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 9'd128;
         decl_ff   <= 16'sd14;
         gain_ff   <= 20'd455903;
      end else if (csr.valid) begin
         case (cidx)
            thfi_pkg::CsrWeight: weight_ff <= cdat[8:0];
            thfi_pkg::CsrDecl:   decl_ff   <= cdat[15:0];
            thfi_pkg::CsrGain:   gain_ff   <= cdat;
            default: ;
         endcase
      end
   end

   logic              push, full, pop, empty;
   thfi_pkg::job_type fjob, qjob;
   thfi_pkg::job_type q_ff [2];
   logic [1:0]        cnt_ff;
   logic              rd_ff, wr_ff;

   thfi_front u_front (
      .clock(clock), .reset(reset), .req(req), .weight(weight_ff),
      .gain(gain_ff), .push(push), .job(fjob), .full(full)
   );

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign qjob  = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) q_ff[wr_ff] <= fjob;
   end

   thfi_back #(.AngleSteps(ANGLE_STEPS)) u_back (
      .clock(clock), .reset(reset), .jvalid(!empty), .job(qjob), .pop(pop),
      .decl(decl_ff), .rsp(rsp)
   );

   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count corrupt");
endmodule
